@@ src/mntp_pkg.sv @@
// ----------------------------------------------------------------------------
// mntp_pkg: shared types and constants for the macro name text parser
// Parser modes, action codes, character codes and the slot lookup.
// ----------------------------------------------------------------------------
package mntp_pkg;

    typedef enum logic [2:0] {
        MODE_ID    = 3'b001,
        MODE_NAME  = 3'b010,
        MODE_VALUE = 3'b100
    } t_mode;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_APPEND = 2'd2
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [2:0] slot;
        logic [7:0] char_out;
    } t_result;

    localparam logic [2:0] NO_SLOT     = 3'd6;
    localparam logic [2:0] ID_TOO_LONG = 3'd4;
    localparam logic [2:0] ID_MAX      = 3'd3;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
    endfunction

    function automatic logic [2:0] slot_of_id(input logic [23:0] id, input logic [2:0] cnt);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [2:0] s;
        a = id[7:0];
        b = id[15:8];
        c = id[23:16];
        s = NO_SLOT;
        if (cnt == 3'd1) begin
            if (a == CH_I) s = 3'd0;
            else if (a == CH_V) s = 3'd4;
        end else if (cnt == 3'd2) begin
            if (a == CH_I && b == CH_I) s = 3'd1;
            else if (a == CH_I && b == CH_V) s = 3'd3;
            else if (a == CH_G && b == CH_ONE) s = 3'd4;
            else if (a == CH_G && b == CH_TWO) s = 3'd5;
            else if (a == CH_V && b == CH_I) s = 3'd5;
        end else if (cnt == 3'd3) begin
            if (a == CH_I && b == CH_I && c == CH_I) s = 3'd2;
        end
        return s;
    endfunction

endpackage

@@ src/mntp_parser.sv @@
// ----------------------------------------------------------------------------
// mntp_parser: parser state machine
// Holds mode, identifier and current slot; decodes one character per enable.
// ----------------------------------------------------------------------------
module mntp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_start_req,
    input  logic [7:0]        i_char_in,
    output mntp_pkg::t_result o_result
);
    import mntp_pkg::*;

    t_mode       r_mode,  n_mode;
    logic [23:0] r_id,    n_id;
    logic [2:0]  r_cnt,   n_cnt;
    logic [2:0]  r_slot,  n_slot;

    t_mode       e_mode;
    logic [23:0] e_id;
    logic [2:0]  e_cnt;
    logic [2:0]  e_slot;
    logic [2:0]  map_slot;

    always_comb begin
        e_mode = i_start_req ? MODE_ID : r_mode;
        e_id   = i_start_req ? 24'd0   : r_id;
        e_cnt  = i_start_req ? 3'd0    : r_cnt;
        e_slot = i_start_req ? NO_SLOT : r_slot;
        map_slot = slot_of_id(e_id, e_cnt);

        n_mode = e_mode;
        n_id   = e_id;
        n_cnt  = e_cnt;
        n_slot = e_slot;
        o_result = '{action: ACT_NONE, slot: 3'd0, char_out: 8'd0};

        unique case (e_mode)
            MODE_NAME: begin
                if (is_space(i_char_in)) begin
                    n_mode = MODE_ID;
                end else if (i_char_in == CH_USCORE) begin
                    n_mode = MODE_VALUE;
                end else if (e_slot < NO_SLOT) begin
                    o_result = '{action: ACT_APPEND, slot: e_slot, char_out: i_char_in};
                end
            end
            MODE_VALUE: begin
                if (is_space(i_char_in)) n_mode = MODE_ID;
            end
            default: begin
                n_mode = MODE_ID;
                if (is_space(i_char_in)) begin
                    n_mode = MODE_ID;
                end else if (i_char_in == CH_EQ) begin
                    n_slot = map_slot;
                    n_id   = 24'd0;
                    n_cnt  = 3'd0;
                    n_mode = MODE_NAME;
                    if (map_slot < NO_SLOT) begin
                        o_result = '{action: ACT_CLEAR, slot: map_slot, char_out: 8'd0};
                    end
                end else if (e_cnt < ID_MAX) begin
                    case (e_cnt[1:0])
                        2'd0:    n_id[7:0]   = i_char_in;
                        2'd1:    n_id[15:8]  = i_char_in;
                        default: n_id[23:16] = i_char_in;
                    endcase
                    n_cnt = e_cnt + 3'd1;
                end else begin
                    n_cnt = ID_TOO_LONG;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ID;
            r_id   <= 24'd0;
            r_cnt  <= 3'd0;
            r_slot <= NO_SLOT;
        end else if (i_en) begin
            r_mode <= n_mode;
            r_id   <= n_id;
            r_cnt  <= n_cnt;
            r_slot <= n_slot;
        end
    end

endmodule

@@ src/macro_name_text_parser_unit.sv @@
// ----------------------------------------------------------------------------
// macro_name_text_parser_unit: preset text macro name parser
// Turns a stream of text characters into slot clear/append events.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready carry one character (i_char_in) and
// a start flag (i_start_req) that restarts parsing before that character.
// Output channel: o_out_valid / i_out_ready carry one event per character:
// o_action (none, clear, append), o_slot and o_char_out.
// Each item is loaded into the input register when it is accepted and is
// then decoded into the result register, which holds its event.
// Throughput: one item per cycle while the receiver is ready; the parser
// state loop is one short decode step, so it never limits the rate.
// When the receiver stalls, the pipeline holds and o_in_ready drops once
// both registers are full; the input register still fills while the
// result waits.
// Reset: synchronous, active low; empties both registers and returns the
// parser to identifier mode with no slot selected.
// ----------------------------------------------------------------------------
module macro_name_text_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_start_req,
    input  logic [7:0] i_char_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_action,
    output logic [2:0] o_slot,
    output logic [7:0] o_char_out
);
    import mntp_pkg::*;

    logic       r_in_valid;
    logic       r_start;
    logic [7:0] r_char;
    logic       r_out_valid;
    t_result    r_res;
    t_result    n_res;
    logic       adv;

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || adv;

    mntp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv && r_in_valid),
        .i_start_req (r_start),
        .i_char_in   (r_char),
        .o_result    (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (adv) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_start <= i_start_req;
            r_char  <= i_char_in;
        end
        if (adv && r_in_valid) r_res <= n_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_action    = r_res.action;
    assign o_slot      = r_res.slot;
    assign o_char_out  = r_res.char_out;

endmodule
